[src/tql_pkg.sv]
// Shared types and constants for the tabular Q-learning engine.
package tql_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_CHOOSE,
        ST_MUL_DISC,
        ST_MUL_OLD,
        ST_MUL_LR,
        ST_WRITE,
        ST_MUL_EPS,
        ST_EPS,
        ST_PUSH
    } t_tql_state;

    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_LEARN  = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_DECAY = 2'd2;

    localparam logic [15:0] LEARN_RATE_RST    = 16'd3277;
    localparam logic [15:0] DISCOUNT_RST      = 16'd32768;
    localparam logic [15:0] EXPLORE_DECAY_RST = 16'd64225;
    localparam logic [15:0] EPSILON_RST       = 16'd64225;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

endpackage

[src/tabular_q_learning_engine.sv]
// Tabular Q-learning engine: Q table, epsilon-greedy choice and Q update.
//
// After reset the block zeroes its Q table, one entry a cycle, with s_axis_tready low
// (configuration writes are taken throughout). Items are then handled one at a time on a
// single 18x17 multiplier and a single-port-read table memory under a small sequencer. A
// choose item scans the state's row, one entry a cycle, and then has its result in the
// output register. A learn item scans the next state's row, then uses the multiplier four
// times (discount, old value times 1-lr, target times lr, epsilon decay) and has its result
// there. A new item is taken once the result has moved into the output register, so one
// result may wait on m_axis while the next item is processed.
module tabular_q_learning_engine #(
    parameter int NUM_STATES  = 4,
    parameter int NUM_ACTIONS = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tql_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // state[1:0], action[3:2], state_after[5:4], reward[21:6],
    // explore_draw[37:22], random_action[39:38]
    input  logic [tql_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op[0]
    input  logic [0:0]                      s_axis_tuser,
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // chosen_action[1:0], explored[2], q_value[18:3], zero[23:19]
    output logic [tql_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int QD  = NUM_STATES * NUM_ACTIONS;
    localparam int QAW = $clog2(QD);
    localparam int SW  = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;
    localparam int AIW = (NUM_ACTIONS > 2) ? $clog2(NUM_ACTIONS) : 1;

    // config and epsilon
    logic [15:0] r_learn_rate, r_discount, r_decay, r_eps;

    // item registers
    logic               r_op;
    logic [QAW-1:0]     r_row_base;
    logic [QAW-1:0]     r_sa;
    logic [AIW-1:0]     r_act;
    logic [AIW-1:0]     r_rand;
    logic [15:0]        r_draw;
    logic signed [15:0] r_reward;

    tql_pkg::t_tql_state r_state, n_state;
    logic [QAW-1:0] r_cnt;

    // table memory
    logic signed [15:0] r_qmem [QD];
    logic signed [15:0] r_rd_data;
    logic               mem_we;
    logic [QAW-1:0]     mem_waddr;
    logic signed [15:0] mem_wdata;
    logic [QAW-1:0]     mem_raddr;

    // scan
    logic               r_rd_vld;
    logic [AIW-1:0]     r_rd_idx;
    logic signed [15:0] r_max;
    logic [AIW-1:0]     r_best;

    // shared multiplier
    logic signed [17:0] mul_a;
    logic        [16:0] mul_b;
    logic signed [35:0] r_prod;
    logic signed [17:0] r_target;
    logic signed [16:0] r_acc;

    // result
    logic [1:0]         r_res_act;
    logic               r_res_expl;
    logic signed [15:0] r_res_q;
    logic               r_out_valid;
    logic [tql_pkg::OUT_DATA_W-1:0] r_out_data;

    // input decode
    logic [1:0]  in_state, in_action, in_next, in_rand;
    logic [SW-1:0]  cl_s, cl_ns;
    logic [AIW-1:0] cl_a, cl_r;
    logic [QAW-1:0] s_base, ns_base;
    logic        in_acc, push_ok;
    logic signed [18:0] nv;
    logic signed [15:0] nv_sat;

    assign in_state  = s_axis_tdata[1:0];
    assign in_action = s_axis_tdata[3:2];
    assign in_next   = s_axis_tdata[5:4];
    assign in_rand   = s_axis_tdata[39:38];

    assign cl_s  = (8'(in_state) >= 8'(NUM_STATES - 1)) ? SW'(NUM_STATES - 1) : SW'(in_state);
    assign cl_ns = (8'(in_next) >= 8'(NUM_STATES - 1)) ? SW'(NUM_STATES - 1) : SW'(in_next);
    assign cl_a  = (8'(in_action) >= 8'(NUM_ACTIONS - 1)) ?
                   AIW'(NUM_ACTIONS - 1) : AIW'(in_action);
    assign cl_r  = (8'(in_rand) >= 8'(NUM_ACTIONS - 1)) ?
                   AIW'(NUM_ACTIONS - 1) : AIW'(in_rand);
    assign s_base  = QAW'(cl_s) * QAW'(NUM_ACTIONS);
    assign ns_base = QAW'(cl_ns) * QAW'(NUM_ACTIONS);

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == tql_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign push_ok       = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // new entry: acc + floor(target*lr), saturated
    assign nv = {{2{r_acc[16]}}, r_acc} + {r_prod[33], r_prod[33:16]};
    assign nv_sat = (nv > 19'sd32767)  ? 16'sh7fff :
                    (nv < -19'sd32768) ? 16'sh8000 : nv[15:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tql_pkg::ST_CLEAR: begin
                if (r_cnt == QAW'(QD - 1)) n_state = tql_pkg::ST_IDLE;
            end
            tql_pkg::ST_IDLE: begin
                if (in_acc) n_state = tql_pkg::ST_SCAN;
            end
            tql_pkg::ST_SCAN: begin
                if (r_cnt == QAW'(NUM_ACTIONS - 1)) n_state = tql_pkg::ST_SCAN_END;
            end
            tql_pkg::ST_SCAN_END: begin
                n_state = (r_op == tql_pkg::OP_LEARN) ? tql_pkg::ST_MUL_DISC : tql_pkg::ST_CHOOSE;
            end
            tql_pkg::ST_CHOOSE:   n_state = tql_pkg::ST_PUSH;
            tql_pkg::ST_MUL_DISC: n_state = tql_pkg::ST_MUL_OLD;
            tql_pkg::ST_MUL_OLD:  n_state = tql_pkg::ST_MUL_LR;
            tql_pkg::ST_MUL_LR:   n_state = tql_pkg::ST_WRITE;
            tql_pkg::ST_WRITE:    n_state = tql_pkg::ST_MUL_EPS;
            tql_pkg::ST_MUL_EPS:  n_state = tql_pkg::ST_EPS;
            tql_pkg::ST_EPS:      n_state = tql_pkg::ST_PUSH;
            tql_pkg::ST_PUSH: begin
                if (push_ok) n_state = tql_pkg::ST_IDLE;
            end
            default:              n_state = tql_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sa;
        mem_wdata = nv_sat;
        mem_raddr = r_row_base + r_cnt;
        mul_a     = {{2{r_max[15]}}, r_max};
        mul_b     = {1'b0, r_discount};
        unique case (r_state)
            tql_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = '0;
            end
            tql_pkg::ST_MUL_DISC: begin
                mem_raddr = r_sa;
            end
            tql_pkg::ST_MUL_OLD: begin
                mul_a = {{2{r_rd_data[15]}}, r_rd_data};
                mul_b = 17'h10000 - {1'b0, r_learn_rate};
            end
            tql_pkg::ST_MUL_LR: begin
                mul_a = r_target;
                mul_b = {1'b0, r_learn_rate};
            end
            tql_pkg::ST_WRITE: begin
                mem_we = 1'b1;
            end
            tql_pkg::ST_MUL_EPS: begin
                mul_a = {2'b00, r_eps};
                mul_b = {1'b0, r_decay};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_qmem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_qmem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, mul_b});
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tql_pkg::ST_CLEAR;
            r_cnt        <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_learn_rate <= tql_pkg::LEARN_RATE_RST;
            r_discount   <= tql_pkg::DISCOUNT_RST;
            r_decay      <= tql_pkg::EXPLORE_DECAY_RST;
            r_eps        <= tql_pkg::EPSILON_RST;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == tql_pkg::ST_SCAN);
            if (r_state == tql_pkg::ST_CLEAR || r_state == tql_pkg::ST_SCAN) begin
                r_cnt <= (n_state == r_state) ? r_cnt + 1'b1 : '0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tql_pkg::CFG_LEARN_RATE:    r_learn_rate <= i_cfg_data;
                    tql_pkg::CFG_DISCOUNT:      r_discount   <= i_cfg_data;
                    tql_pkg::CFG_EXPLORE_DECAY: r_decay      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == tql_pkg::ST_EPS) r_eps <= r_prod[31:16];
            if (r_state == tql_pkg::ST_PUSH && push_ok) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= s_axis_tuser[0];
            r_row_base <= (s_axis_tuser[0] == tql_pkg::OP_LEARN) ? ns_base : s_base;
            r_sa       <= s_base + QAW'(cl_a);
            r_act      <= cl_a;
            r_rand     <= cl_r;
            r_draw     <= s_axis_tdata[37:22];
            r_reward   <= s_axis_tdata[21:6];
        end
        r_rd_idx <= r_cnt[AIW-1:0];
        if (r_rd_vld && (r_rd_idx == '0 || r_rd_data > r_max)) begin
            r_max  <= r_rd_data;
            r_best <= r_rd_idx;
        end
        if (r_state == tql_pkg::ST_MUL_OLD) begin
            r_target <= {{2{r_reward[15]}}, r_reward} + {r_prod[32], r_prod[32:16]};
        end
        if (r_state == tql_pkg::ST_MUL_LR) r_acc <= r_prod[32:16];
        if (r_state == tql_pkg::ST_CHOOSE) begin
            r_res_q <= r_max;
            if (r_draw < r_eps) begin
                r_res_act  <= 2'(r_rand);
                r_res_expl <= 1'b1;
            end else begin
                r_res_act  <= 2'(r_best);
                r_res_expl <= 1'b0;
            end
        end
        if (r_state == tql_pkg::ST_WRITE) begin
            r_res_q    <= nv_sat;
            r_res_act  <= 2'(r_act);
            r_res_expl <= 1'b0;
        end
        if (r_state == tql_pkg::ST_PUSH && push_ok) begin
            r_out_data <= {5'b0, r_res_q, r_res_expl, r_res_act};
        end
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input taken twice in a row");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == tql_pkg::ST_PUSH))
        else $error("result raised outside push");

    a_eps_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_eps) |-> ($past(r_state == tql_pkg::ST_EPS) || $past(!i_rst_n)))
        else $error("epsilon changed outside its update");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tql_pkg::ST_SCAN) |-> (r_cnt <= QAW'(NUM_ACTIONS - 1)))
        else $error("scan ran past the row");

endmodule
